// ===== rtl/sqvg_pkg.sv =====
// Package for the sprite quad vertex generator: word structs and constants.
// No dependencies.
`default_nettype none
package sqvg_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] half_width;
    logic signed [31:0] half_height;
    logic        [31:0] texture_id;
  } sqvg_in_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic        [1:0]  corner;
    logic        [4:0]  slot;
    logic               flush_before;
    logic               last;
  } sqvg_out_t;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;

  function automatic logic signed [33:0] turn_atan(input logic [4:0] i);
    case (i)
      5'd0:  turn_atan = 34'sd536870912;
      5'd1:  turn_atan = 34'sd316933406;
      5'd2:  turn_atan = 34'sd167458907;
      5'd3:  turn_atan = 34'sd85004756;
      5'd4:  turn_atan = 34'sd42667331;
      5'd5:  turn_atan = 34'sd21354465;
      5'd6:  turn_atan = 34'sd10679838;
      5'd7:  turn_atan = 34'sd5340245;
      5'd8:  turn_atan = 34'sd2670163;
      5'd9:  turn_atan = 34'sd1335087;
      5'd10: turn_atan = 34'sd667544;
      5'd11: turn_atan = 34'sd333772;
      5'd12: turn_atan = 34'sd166886;
      5'd13: turn_atan = 34'sd83443;
      5'd14: turn_atan = 34'sd41722;
      5'd15: turn_atan = 34'sd20861;
      5'd16: turn_atan = 34'sd10430;
      5'd17: turn_atan = 34'sd5215;
      5'd18: turn_atan = 34'sd2608;
      5'd19: turn_atan = 34'sd1304;
      5'd20: turn_atan = 34'sd652;
      5'd21: turn_atan = 34'sd326;
      5'd22: turn_atan = 34'sd163;
      5'd23: turn_atan = 34'sd81;
      default: turn_atan = 34'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sqvg_cordic.sv =====
// Iterative sine/cosine unit: angle to binary angle by a byte-wise reciprocal
// divide by 45, then one CORDIC rotation per cycle. Depends on sqvg_pkg.
`default_nettype none
module sqvg_cordic
  import sqvg_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] deg,
  output logic                    done,
  output logic signed [33:0]      cos_q,
  output logic signed [33:0]      sin_q
);

  localparam int YSH = 29 - FRACTION_BITS;
  localparam logic signed [63:0] KOFF = 64'sd45 <<< 53;
  localparam logic [13:0] RECIP45 = 14'd11651;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001, C_DIV = 4'b0010, C_ROT = 4'b0100, C_OUT = 4'b1000
  } cst_t;

  cst_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] num_r, num_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [31:0] q_r, q_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic flip_r, flip_nxt;

  logic signed [63:0] yd;
  logic [13:0] nd;
  logic [27:0] qprod;
  logic [7:0]  qd;
  logic [13:0] qm;
  logic [31:0] ba;
  logic signed [33:0] dx, dy, xf, yf;

  always_comb begin
    yd = 64'(deg) <<< YSH;
    nd = {rem_r, num_r[63:56]};
    qprod = 28'(nd) * 28'(RECIP45);
    qd = qprod[26:19];
    qm = 14'(qd) * 14'd45;
    dx = y_r >>> cnt_r[4:0];
    dy = x_r >>> cnt_r[4:0];
    ba = q_r;
    xf = flip_r ? -x_r : x_r;
    yf = flip_r ? -y_r : y_r;
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    flip_nxt = flip_r;
    case (state_r)
      C_IDLE: if (start) begin
        num_nxt = 64'(yd + KOFF);
        rem_nxt = '0;
        cnt_nxt = 6'd8;
        state_nxt = C_DIV;
      end
      C_DIV: begin
        if (cnt_r == 0) begin
          flip_nxt = ba[30] ^ ba[31];
          z_nxt = 34'(signed'({ba[31] ^ (ba[30] ^ ba[31]), ba[30:0]}));
          x_nxt = CORDIC_GAIN;
          y_nxt = '0;
          cnt_nxt = '0;
          state_nxt = C_ROT;
        end else begin
          rem_nxt = 6'(nd - qm);
          q_nxt = {q_r[23:0], qd};
          num_nxt = num_r << 8;
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      C_ROT: begin
        if (z_r >= 0) begin
          x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - turn_atan(cnt_r[4:0]);
        end else begin
          x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + turn_atan(cnt_r[4:0]);
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(CORDIC_STEPS - 1)) state_nxt = C_OUT;
      end
      C_OUT: state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  assign done = (state_r == C_OUT);
  assign cos_q = (xf > Q30_ONE) ? Q30_ONE : (xf < -Q30_ONE) ? -Q30_ONE : xf;
  assign sin_q = (yf > Q30_ONE) ? Q30_ONE : (yf < -Q30_ONE) ? -Q30_ONE : yf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    flip_r <= flip_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/sqvg_slots.sv =====
// Texture slot table with a sequential search, one entry per cycle.
// Depends on sqvg_pkg.
`default_nettype none
module sqvg_slots
  import sqvg_pkg::*;
#(
  parameter int TEXTURE_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] id,
  output logic             done,
  output logic [4:0]       slot,
  output logic             flush
);

  localparam int IW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
  localparam int CW = $clog2(TEXTURE_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_SCAN = 3'b010, S_DONE = 3'b100
  } sst_t;

  sst_t state_r;
  logic [31:0] table_r [TEXTURE_SLOTS];
  logic [31:0] id_r;
  logic [CW-1:0] used_r, idx_r;
  logic [4:0] slot_r;
  logic flush_r;

  assign done = (state_r == S_DONE);
  assign slot = slot_r;
  assign flush = flush_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (start) begin
          id_r <= id;
          idx_r <= '0;
          flush_r <= 1'b0;
          if (id == 32'd0) begin
            slot_r <= '0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_r < used_r) begin
            if (table_r[idx_r[IW-1:0]] == id_r) begin
              slot_r <= 5'(idx_r + CW'(1));
              state_r <= S_DONE;
            end
            idx_r <= idx_r + CW'(1);
          end else if (used_r >= CW'(TEXTURE_SLOTS)) begin
            table_r[0] <= id_r;
            used_r <= CW'(1);
            slot_r <= 5'd1;
            flush_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            table_r[used_r[IW-1:0]] <= id_r;
            used_r <= used_r + CW'(1);
            slot_r <= 5'(used_r + CW'(1));
            state_r <= S_DONE;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sprite_quad_vertex_generator.sv =====
// Top level: sequencer around one shared 34x34 multiplier, CORDIC unit and
// slot search. Depends on sqvg_pkg, sqvg_cordic and sqvg_slots.
//
//  channel | ports                  | dir
//  input   | in_valid/in_ready/in_data   | in
//  result  | out_valid/out_ready/out_data | out
//
// Per sprite, three angles in turn (start, 8 divide steps, setup, 24 CORDIC
// steps, done), then for each corner 12 multiplies on the single multiplier,
// an emit and a hand-over, and finally a return to idle.
// The slot search runs alongside the first angle.
// Reset clears the sequencer and the slot count. A stalled result holds.
`default_nettype none
module sprite_quad_vertex_generator
  import sqvg_pkg::*;
#(
  parameter int TEXTURE_SLOTS = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire sqvg_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output sqvg_out_t      out_data
);

  typedef enum logic [6:0] {
    T_IDLE = 7'b0000001, T_TRIG = 7'b0000010, T_WAIT = 7'b0000100,
    T_MUL  = 7'b0001000, T_EMIT = 7'b0010000, T_HOLD = 7'b0100000,
    T_SLOT = 7'b1000000
  } tst_t;

  tst_t state_r;
  sqvg_in_t d_r;
  logic [1:0] ax_r;
  logic signed [33:0] cxa_r, sxa_r, cya_r, sya_r, cza_r, sza_r;
  logic [1:0] k_r;
  logic [3:0] op_r;
  logic signed [33:0] u_r, v_r, a_r, b_r, r_r, vx_r, vy_r, vz_r, t_r;
  logic [4:0] slot_r;
  logic flush_r, sdone_r;
  sqvg_out_t o_r;

  logic c_start, c_done;
  logic signed [31:0] c_deg;
  logic signed [33:0] c_cos, c_sin;
  logic s_start, s_done, s_flush;
  logic [4:0] s_slot;

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic [5:0] sh;
  logic signed [67:0] shp;
  logic signed [33:0] mres, sat_m;
  logic signed [33:0] ex, ey, sx, sy, sz;

  function automatic logic signed [33:0] sat34(input logic signed [67:0] v);
    if (v > 68'sd2147483647) sat34 = 34'sd2147483647;
    else if (v < -68'sd2147483648) sat34 = -34'sd2147483648;
    else sat34 = v[33:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) sat32 = 32'h7fffffff;
    else if (v < -34'sd2147483648) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction

  sqvg_cordic #(.FRACTION_BITS(FRACTION_BITS)) u_cordic (
    .clk, .rst_n, .start(c_start), .deg(c_deg), .done(c_done),
    .cos_q(c_cos), .sin_q(c_sin)
  );

  sqvg_slots #(.TEXTURE_SLOTS(TEXTURE_SLOTS)) u_slots (
    .clk, .rst_n, .start(s_start), .id(d_r.texture_id), .done(s_done),
    .slot(s_slot), .flush(s_flush)
  );

  assign c_deg = (ax_r == 2'd0) ? d_r.angle_x : (ax_r == 2'd1) ? d_r.angle_y : d_r.angle_z;
  assign c_start = (state_r == T_TRIG);
  assign s_start = (state_r == T_TRIG) && (ax_r == 2'd0);
  assign in_ready = (state_r == T_IDLE);
  assign out_valid = (state_r == T_HOLD);
  assign out_data = o_r;

  always_comb begin
    ex = (k_r < 2'd2) ? -34'(d_r.half_width) : 34'(d_r.half_width);
    ey = (k_r == 2'd0 || k_r == 2'd3) ? -34'(d_r.half_height) : 34'(d_r.half_height);
    ma = '0; mb = '0; sh = 6'd30;
    case (op_r)
      4'd0: begin ma = 34'(d_r.scale_x); mb = ex; sh = 6'(FRACTION_BITS); end
      4'd1: begin ma = 34'(d_r.scale_y); mb = ey; sh = 6'(FRACTION_BITS); end
      4'd2: begin ma = cza_r; mb = u_r; end
      4'd3: begin ma = sza_r; mb = v_r; end
      4'd4: begin ma = sza_r; mb = u_r; end
      4'd5: begin ma = cza_r; mb = v_r; end
      4'd6: begin ma = cya_r; mb = a_r; end
      4'd7: begin ma = sya_r; mb = a_r; end
      4'd8: begin ma = cxa_r; mb = b_r; end
      4'd9: begin ma = sxa_r; mb = r_r; end
      4'd10: begin ma = sxa_r; mb = b_r; end
      4'd11: begin ma = cxa_r; mb = r_r; end
      default: ;
    endcase
    prod = ma * mb;
    shp = prod >>> sh;
    mres = shp[33:0];
    sat_m = sat34(shp);
    sx = 34'(d_r.pos_x) + vx_r;
    sy = 34'(d_r.pos_y) + vy_r;
    sz = 34'(d_r.pos_z) + vz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      case (state_r)
        T_IDLE: if (in_valid) begin
          d_r <= in_data;
          ax_r <= 2'd0;
          sdone_r <= 1'b0;
          k_r <= 2'd0;
          state_r <= T_TRIG;
        end
        T_TRIG: state_r <= T_WAIT;
        T_WAIT: if (c_done) begin
          case (ax_r)
            2'd0: begin cxa_r <= c_cos; sxa_r <= c_sin; end
            2'd1: begin cya_r <= c_cos; sya_r <= c_sin; end
            default: begin cza_r <= c_cos; sza_r <= c_sin; end
          endcase
          if (ax_r == 2'd2) begin
            state_r <= T_SLOT;
          end else begin
            ax_r <= ax_r + 2'd1;
            state_r <= T_TRIG;
          end
        end
        T_SLOT: if (sdone_r) begin
          op_r <= 4'd0;
          state_r <= T_MUL;
        end
        T_MUL: begin
          op_r <= op_r + 4'd1;
          case (op_r)
            4'd0: u_r <= sat_m;
            4'd1: v_r <= sat_m;
            4'd2: t_r <= mres;
            4'd3: a_r <= t_r - mres;
            4'd4: t_r <= mres;
            4'd5: b_r <= t_r + mres;
            4'd6: vx_r <= mres;
            4'd7: r_r <= -mres;
            4'd8: t_r <= mres;
            4'd9: vy_r <= t_r - mres;
            4'd10: t_r <= mres;
            default: begin vz_r <= t_r + mres; state_r <= T_EMIT; end
          endcase
        end
        T_EMIT: begin
          o_r.vertex_x <= sat32(sx);
          o_r.vertex_y <= sat32(sy);
          o_r.vertex_z <= sat32(sz);
          o_r.corner <= k_r;
          o_r.slot <= slot_r;
          o_r.flush_before <= flush_r && (k_r == 2'd0);
          o_r.last <= (k_r == 2'd3);
          state_r <= T_HOLD;
        end
        T_HOLD: if (out_ready) begin
          if (k_r == 2'd3) begin
            state_r <= T_IDLE;
          end else begin
            k_r <= k_r + 2'd1;
            op_r <= 4'd0;
            state_r <= T_MUL;
          end
        end
        default: state_r <= T_IDLE;
      endcase
      if (s_done) begin
        sdone_r <= 1'b1;
        slot_r <= s_slot;
        flush_r <= s_flush;
      end
    end
  end

endmodule
`default_nettype wire
